@@ rtl/sexpr_stream_tokenizer_defines.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef SEXPR_STREAM_TOKENIZER_DEFINES_SVH
`define SEXPR_STREAM_TOKENIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sst_pkg.sv @@
// Package with the widths, lexical mode codes, event codes, character codes and step result type of the tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

	localparam int MODE_W = 3;
	localparam int EV_W   = 3;
	localparam int CHAR_W = 8;
	localparam int NEST_W = 7;

	localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SYMBOL  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STRING  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ESCAPE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd4;

	localparam logic [EV_W-1:0] EV_SKIP   = 3'd0;
	localparam logic [EV_W-1:0] EV_OPEN   = 3'd1;
	localparam logic [EV_W-1:0] EV_CLOSE  = 3'd2;
	localparam logic [EV_W-1:0] EV_SYMBOL = 3'd3;
	localparam logic [EV_W-1:0] EV_STRING = 3'd4;
	localparam logic [EV_W-1:0] EV_ERROR  = 3'd5;
	localparam logic [EV_W-1:0] EV_NOEXPR = 3'd6;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [EV_W-1:0]   ev;
		logic [CHAR_W-1:0] chr;
		logic              sym_end;
		logic              done;
	} step_t;

endpackage

`default_nettype wire

@@ rtl/sst_lexer.sv @@
// Combinational next-mode, next-depth and event logic for one text byte.
`timescale 1ns / 1ps
`default_nettype none

module sst_lexer import sst_pkg::*; #(
	parameter int MAX_DEPTH = 64,
	parameter int DEPTH_W   = 7
) (
	input  wire logic [CHAR_W-1:0]  text_byte,
	input  wire logic [MODE_W-1:0]  mode,
	input  wire logic [DEPTH_W-1:0] depth,
	output step_t                   step,
	output logic [DEPTH_W-1:0]      depth_next
);

	logic               is_space;
	logic               is_delim;
	logic               depth_zero;
	logic               at_max;
	logic               done_pre;
	logic [MODE_W-1:0]  b_mode;
	logic [DEPTH_W-1:0] b_depth;
	logic [EV_W-1:0]    b_ev;
	logic [CHAR_W-1:0]  b_chr;
	logic               b_done;

	assign is_space   = (text_byte == CH_SPACE) ||
	                    ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
	assign is_delim   = (text_byte == CH_NUL) || (text_byte == CH_LPAREN) ||
	                    (text_byte == CH_RPAREN) || (text_byte == CH_SEMI) || is_space;
	assign depth_zero = (depth == '0);
	assign at_max     = (depth >= DEPTH_W'(MAX_DEPTH));

	// A symbol ended by a delimiter, or a string cut off by the zero byte, at depth zero completes
	// an expression before the terminating byte is handled on its own.
	always_comb begin
		done_pre = 1'b0;
		unique case (mode)
			MODE_SYMBOL: begin
				done_pre = is_delim && depth_zero;
			end
			MODE_STRING, MODE_ESCAPE: begin
				done_pre = (text_byte == CH_NUL) && depth_zero;
			end
			default: begin
				done_pre = 1'b0;
			end
		endcase
	end

	// Handling of a byte that starts from the between-tokens mode.
	always_comb begin
		b_mode  = MODE_BETWEEN;
		b_depth = depth;
		b_ev    = EV_SKIP;
		b_chr   = '0;
		b_done  = 1'b0;
		priority if (text_byte == CH_NUL) begin
			b_depth = '0;
			if (!depth_zero) begin
				b_ev = EV_ERROR;
			end else if (done_pre) begin
				b_ev = EV_SKIP;
			end else begin
				b_ev = EV_NOEXPR;
			end
		end else if (is_space) begin
			b_ev = EV_SKIP;
		end else if (text_byte == CH_SEMI) begin
			b_mode = MODE_COMMENT;
		end else if (text_byte == CH_LPAREN) begin
			if (at_max) begin
				b_ev    = EV_ERROR;
				b_depth = '0;
			end else begin
				b_ev    = EV_OPEN;
				b_depth = depth + DEPTH_W'(1);
			end
		end else if (text_byte == CH_RPAREN) begin
			if (depth_zero) begin
				b_ev = EV_ERROR;
			end else begin
				b_ev    = EV_CLOSE;
				b_depth = depth - DEPTH_W'(1);
				b_done  = (depth == DEPTH_W'(1));
			end
		end else begin
			b_chr = text_byte;
			if (text_byte == CH_QUOTE) begin
				b_mode = MODE_STRING;
				b_ev   = EV_STRING;
			end else begin
				b_mode = MODE_SYMBOL;
				b_ev   = EV_SYMBOL;
			end
		end
	end

	always_comb begin
		step.mode    = mode;
		step.ev      = EV_SKIP;
		step.chr     = '0;
		step.sym_end = 1'b0;
		step.done    = 1'b0;
		depth_next   = depth;
		unique case (mode)
			MODE_SYMBOL: begin
				if (is_delim) begin
					step.mode    = b_mode;
					step.ev      = b_ev;
					step.chr     = b_chr;
					step.sym_end = 1'b1;
					step.done    = done_pre | b_done;
					depth_next   = b_depth;
				end else begin
					step.chr = text_byte;
					step.ev  = EV_SYMBOL;
				end
			end
			MODE_STRING, MODE_ESCAPE: begin
				if (text_byte == CH_NUL) begin
					step.mode  = b_mode;
					step.ev    = b_ev;
					step.chr   = b_chr;
					step.done  = done_pre | b_done;
					depth_next = b_depth;
				end else begin
					step.chr = text_byte;
					step.ev  = EV_STRING;
					if (mode == MODE_ESCAPE) begin
						step.mode = MODE_STRING;
					end else if (text_byte == CH_BSLASH) begin
						step.mode = MODE_ESCAPE;
					end else if (text_byte == CH_QUOTE) begin
						step.mode = MODE_BETWEEN;
						step.done = depth_zero;
					end
				end
			end
			MODE_COMMENT: begin
				if (text_byte == CH_NUL) begin
					step.mode  = b_mode;
					step.ev    = b_ev;
					step.chr   = b_chr;
					step.done  = b_done;
					depth_next = b_depth;
				end else if (text_byte == CH_NL) begin
					step.mode = MODE_BETWEEN;
				end
			end
			default: begin
				step.mode  = b_mode;
				step.ev    = b_ev;
				step.chr   = b_chr;
				step.done  = b_done;
				depth_next = b_depth;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/sexpr_stream_tokenizer.sv @@
// Top level of the S-expression byte tokenizer: input register, lexer state and result register.
//
// Usage: one text byte per beat on the input channel (in_valid, in_stall, text_byte);
// a zero byte ends a text. Every input beat gives exactly one result beat on the
// output channel (out_valid, out_stall) carrying event_kind, char_out,
// symbol_ended, expr_done and nest_level.
// Path: a taken byte is held in the input register, classified by the lexer and written
// to the result register once that register is free to take it.
// Throughput: one byte per cycle while out_stall does not hold the result; the only loop is
// the mode and depth update in the lexer, which is combinational.
// Reset: arst_n low clears both registers' valid flags, sets the mode to between
// tokens and the depth to zero; no clearing pass is needed.
// Stall: while out_stall holds a pending result, that result stays put; the input
// register still takes one more byte, after which in_stall rises until the result
// register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "sexpr_stream_tokenizer_defines.svh"

module sexpr_stream_tokenizer import sst_pkg::*; #(
	parameter int MAX_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CHAR_W-1:0] text_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [EV_W-1:0]        event_kind,
	output logic [CHAR_W-1:0]      char_out,
	output logic                   symbol_ended,
	output logic                   expr_done,
	output logic [NEST_W-1:0]      nest_level
);

	localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

	logic               valid_s1;
	logic [CHAR_W-1:0]  text_byte_s1;
	logic [MODE_W-1:0]  lex_mode_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               out_valid_q;
	logic [EV_W-1:0]    event_kind_q;
	logic [CHAR_W-1:0]  char_out_q;
	logic               symbol_ended_q;
	logic               expr_done_q;
	logic [NEST_W-1:0]  nest_level_q;

	logic               out_free;
	logic               fire_s1;
	logic               in_take;
	step_t              step;
	logic [DEPTH_W-1:0] depth_next;

	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	sst_lexer #(
		.MAX_DEPTH (MAX_DEPTH),
		.DEPTH_W   (DEPTH_W)
	) u_lexer (
		.text_byte  (text_byte_s1),
		.mode       (lex_mode_q),
		.depth      (depth_q),
		.step       (step),
		.depth_next (depth_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			text_byte_s1 <= text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_mode_q  <= MODE_BETWEEN;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				lex_mode_q  <= step.mode;
				depth_q     <= depth_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			event_kind_q   <= step.ev;
			char_out_q     <= step.chr;
			symbol_ended_q <= step.sym_end;
			expr_done_q    <= step.done;
			nest_level_q   <= NEST_W'(depth_next);
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = event_kind_q;
	assign char_out     = char_out_q;
	assign symbol_ended = symbol_ended_q;
	assign expr_done    = expr_done_q;
	assign nest_level   = nest_level_q;

	`SST_ASSERT_NEXT(a_error_resets_state, clk, arst_n, fire_s1 && (step.ev == EV_ERROR), (depth_q == '0) && (lex_mode_q == MODE_BETWEEN), "error beat did not return lexer to idle")
	`SST_ASSERT_NOW(a_depth_bounded, clk, arst_n, 1'b1, depth_q <= DEPTH_W'(MAX_DEPTH), "nesting depth above limit")
	`SST_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, valid_s1 && out_valid_q && out_stall, "input stalled without a blocked result")
	`SST_ASSERT_NOW(a_sym_end_kind, clk, arst_n, out_valid_q && symbol_ended_q, (event_kind_q != EV_SYMBOL) && (event_kind_q != EV_STRING), "symbol end flagged on a text byte event")

endmodule

`default_nettype wire
